[design/tccw_pkg.sv]
package tccw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// fixed field widths
	localparam int LOC_W   = 11;
	localparam int INDEX_W = 11;

	// item modes
	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// white on black space
	localparam logic [15:0] BLANK_CELL = 16'h0F20;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         char_code;
		logic [3:0]         back_color;
		logic [3:0]         fore_color;
		logic [INDEX_W-1:0] read_index;
	} item_t;

	typedef struct packed {
		logic [LOC_W-1:0] cursor_pos;
		logic [15:0]      cell_value;
	} result_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

[design/text_console_cell_writer.sv]
// Text console cell writer: a COLUMNS x ROWS screen of 16-bit cells (attribute
// high byte, character low byte) held in one single-port-write, registered-read
// memory, plus a cursor. Items arrive on item/item_valid/item_stall and each
// gives one result on result/result_valid/result_stall. After reset the block
// blanks all COLUMNS*ROWS cells (2000 by default) one cell per cycle, and
// stalls items meanwhile. A put is accepted, then does the memory write (for a
// printable byte only) and the cursor update; a read is accepted, then issues
// the memory read, then takes the registered read data. A clear walks every
// cell. A put that moves the cursor off the last row adds a scroll pass: each
// cell is read COLUMNS entries ahead and written back in the next cycle, and
// the last row is filled with blanks in the same pass. A new item is taken
// while the last result still waits in the output register; it completes
// once that is taken.
module text_console_cell_writer #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  tccw_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output tccw_pkg::result_t result
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS + 8);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int SW    = $clog2(CELLS + COLUMNS + 1);
	localparam int IW    = (AW >= tccw_pkg::INDEX_W) ? AW + 1 : tccw_pkg::INDEX_W + 1;
	localparam int LOCW  = (AW > tccw_pkg::LOC_W) ? AW : tccw_pkg::LOC_W;

	// screen memory
	logic [15:0] mem_q [CELLS];
	logic [15:0] rdata_q;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0] mem_wdata;
	logic        mem_re;
	logic [AW-1:0] mem_raddr;

	// control state
	tccw_pkg::state_t state_q, state_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [SW-1:0] sweep_q, sweep_d;
	logic [15:0]   value_q, value_d;
	tccw_pkg::item_t item_q;

	// scroll write-back stage, in the cycle after the read
	logic          cp_we_s1, cp_we_d;
	logic [AW-1:0] cp_addr_s1, cp_addr_d;
	logic          cp_blank_s1, cp_blank_d;

	// output register
	logic              result_valid_q;
	tccw_pkg::result_t result_q;
	logic              finish;
	logic              load;

	// put decode
	logic [CW-1:0] put_col;
	logic [RW-1:0] put_row;
	logic          put_write;
	logic          put_scroll;
	logic [AW-1:0] put_addr;
	logic [SW-1:0] sweep_back;
	logic          read_in_range;
	logic [LOCW-1:0] loc_w;

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	// cursor motion for a put, from the current cursor
	always_comb begin
		logic [CW-1:0] c;
		logic [RW-1:0] r;
		c = col_q;
		r = row_q;
		put_write = 1'b0;
		unique case (item_q.char_code)
			tccw_pkg::CH_BS: begin
				if (col_q != '0) begin
					c = col_q - CW'(1);
				end
			end
			tccw_pkg::CH_TAB: begin
				c = (col_q + CW'(8)) & ~CW'(7);
			end
			tccw_pkg::CH_CR: begin
				c = '0;
			end
			tccw_pkg::CH_LF: begin
				c = '0;
				r = row_q + RW'(1);
			end
			default: begin
				// printable range, high half ignored
				if (item_q.char_code >= tccw_pkg::CH_SPACE && !item_q.char_code[7]) begin
					put_write = 1'b1;
					c = col_q + CW'(1);
				end
			end
		endcase
		// line wrap
		if (c >= CW'(COLUMNS)) begin
			c = '0;
			r = r + RW'(1);
		end
		put_scroll = (r >= RW'(ROWS));
		if (put_scroll) begin
			r = RW'(ROWS - 1);
		end
		put_col = c;
		put_row = r;
	end

	assign put_addr      = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign sweep_back    = sweep_q - SW'(COLUMNS);
	assign read_in_range = IW'(item_q.read_index) < IW'(CELLS);

	// sequencer
	always_comb begin
		state_d    = state_q;
		col_d      = col_q;
		row_d      = row_q;
		sweep_d    = sweep_q;
		value_d    = value_q;
		item_stall = 1'b1;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = tccw_pkg::BLANK_CELL;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		cp_we_d    = 1'b0;
		cp_addr_d  = '0;
		cp_blank_d = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			tccw_pkg::ST_INIT: begin
				// blank every cell after reset
				mem_we    = 1'b1;
				mem_waddr = sweep_q[AW-1:0];
				if (sweep_q == SW'(CELLS - 1)) begin
					sweep_d = '0;
					state_d = tccw_pkg::ST_IDLE;
				end else begin
					sweep_d = sweep_q + SW'(1);
				end
			end
			tccw_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				value_d    = '0;
				if (item_valid) begin
					state_d = tccw_pkg::ST_EXEC;
				end
			end
			tccw_pkg::ST_EXEC: begin
				unique case (item_q.mode)
					tccw_pkg::MODE_PUT: begin
						mem_we    = put_write;
						mem_waddr = put_addr;
						mem_wdata = {item_q.back_color, item_q.fore_color, item_q.char_code};
						col_d     = put_col;
						row_d     = put_row;
						if (put_scroll) begin
							// first read is the start of row 1
							sweep_d = SW'(COLUMNS);
							state_d = tccw_pkg::ST_SCROLL;
						end else begin
							finish = 1'b1;
						end
					end
					tccw_pkg::MODE_CLEAR: begin
						col_d   = '0;
						row_d   = '0;
						sweep_d = '0;
						state_d = tccw_pkg::ST_CLEAR;
					end
					tccw_pkg::MODE_READ: begin
						if (read_in_range) begin
							mem_re    = 1'b1;
							mem_raddr = AW'(item_q.read_index);
							state_d   = tccw_pkg::ST_READ;
						end else begin
							finish = 1'b1;
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			tccw_pkg::ST_READ: begin
				value_d = rdata_q;
				finish  = 1'b1;
			end
			tccw_pkg::ST_SCROLL: begin
				// read a row ahead; past the end the write-back is a blank
				if (sweep_q < SW'(CELLS)) begin
					mem_re    = 1'b1;
					mem_raddr = sweep_q[AW-1:0];
				end
				cp_we_d    = 1'b1;
				cp_addr_d  = sweep_back[AW-1:0];
				cp_blank_d = (sweep_q >= SW'(CELLS));
				if (sweep_q == SW'(CELLS + COLUMNS - 1)) begin
					sweep_d = '0;
					state_d = tccw_pkg::ST_DONE;
				end else begin
					sweep_d = sweep_q + SW'(1);
				end
			end
			tccw_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q[AW-1:0];
				if (sweep_q == SW'(CELLS - 1)) begin
					sweep_d = '0;
					finish  = 1'b1;
				end else begin
					sweep_d = sweep_q + SW'(1);
				end
			end
			tccw_pkg::ST_DONE: begin
				finish = 1'b1;
			end
			default: begin
				state_d = tccw_pkg::ST_IDLE;
			end
		endcase

		// scroll write-back owns the write port when pending
		if (cp_we_s1) begin
			mem_we    = 1'b1;
			mem_waddr = cp_addr_s1;
			mem_wdata = cp_blank_s1 ? tccw_pkg::BLANK_CELL : rdata_q;
		end

		// result goes out once the output register is free
		load = finish && (!result_valid_q || !result_stall);
		if (finish) begin
			state_d = load ? tccw_pkg::ST_IDLE : tccw_pkg::ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tccw_pkg::ST_INIT;
			col_q          <= '0;
			row_q          <= '0;
			sweep_q        <= '0;
			cp_we_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			col_q    <= col_d;
			row_q    <= row_d;
			sweep_q  <= sweep_d;
			cp_we_s1 <= cp_we_d;
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// cursor location after the step
	assign loc_w = LOCW'(row_d) * LOCW'(COLUMNS) + LOCW'(col_d);

	always_ff @(posedge clk) begin
		value_q     <= value_d;
		cp_addr_s1  <= cp_addr_d;
		cp_blank_s1 <= cp_blank_d;
		if (state_q == tccw_pkg::ST_IDLE && item_valid) begin
			item_q <= item;
		end
		if (load) begin
			result_q.cursor_pos <= loc_w[tccw_pkg::LOC_W-1:0];
			result_q.cell_value <= value_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

	// screen geometry at the block's default parameters
	localparam int COLS  = tccw_pkg::COLUMNS_DEF;
	localparam int LINES = tccw_pkg::ROWS_DEF;
	localparam int CELLS = COLS * LINES;

	// codes the package does not name
	localparam logic [1:0] MODE_UNUSED   = 2'd3;
	localparam logic [7:0] CH_LAST_PRINT = 8'h7F;
	localparam int         TAB_STOP      = 8;

	localparam int PHASE_ITEMS = 213;
	localparam int DIR_N       = 24;

	// directed stimulus: an item plus, where obvious, the result it must give
	typedef struct packed {
		tccw_pkg::item_t   stim;
		logic              known;
		tccw_pkg::result_t res;
	} directed_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	tccw_pkg::item_t   item_bus;
	logic              result_valid;
	logic              result_stall;
	tccw_pkg::result_t result_bus;

	// shadow of the screen and cursor
	logic [15:0] shadow_cells [0:CELLS-1];
	int unsigned shadow_col;
	int unsigned shadow_row;

	tccw_pkg::result_t expected_results [$];
	tccw_pkg::result_t exp_res;

	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int n_in, n_out, n_read, n_wrap, n_scroll, n_clear;

	directed_row_t directed_rows [0:DIR_N-1] = '{
		// fresh screen: both ends of the store read blank
		'{'{tccw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd0}, 1'b1,
			'{11'd0, tccw_pkg::BLANK_CELL}},
		'{'{tccw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd1999}, 1'b1,
			'{11'd0, tccw_pkg::BLANK_CELL}},
		// index with every bit set lies off the screen
		'{'{tccw_pkg::MODE_READ, 8'hFF, 4'hF, 4'hF, 11'h7FF}, 1'b1, '{11'd0, 16'h0000}},
		// unused mode changes nothing
		'{'{MODE_UNUSED, 8'hFF, 4'hF, 4'hF, 11'h7FF}, 1'b1, '{11'd0, 16'h0000}},
		// printable range edges and color extremes
		'{'{tccw_pkg::MODE_PUT, 8'h41, 4'hF, 4'h0, 11'd0}, 1'b1, '{11'd1, 16'h0000}},
		'{'{tccw_pkg::MODE_PUT, CH_LAST_PRINT, 4'h0, 4'hF, 11'd0}, 1'b1, '{11'd2, 16'h0000}},
		'{'{tccw_pkg::MODE_PUT, tccw_pkg::CH_SPACE, 4'h5, 4'hA, 11'd0}, 1'b1,
			'{11'd3, 16'h0000}},
		// bytes that move nothing: stray control, high half, zero
		'{'{tccw_pkg::MODE_PUT, 8'h1F, 4'h3, 4'h3, 11'd0}, 1'b1, '{11'd3, 16'h0000}},
		'{'{tccw_pkg::MODE_PUT, 8'h80, 4'h3, 4'h3, 11'd0}, 1'b1, '{11'd3, 16'h0000}},
		'{'{tccw_pkg::MODE_PUT, 8'hFF, 4'h3, 4'h3, 11'd0}, 1'b1, '{11'd3, 16'h0000}},
		'{'{tccw_pkg::MODE_PUT, 8'h00, 4'h3, 4'h3, 11'd0}, 1'b1, '{11'd3, 16'h0000}},
		// read back what was written
		'{'{tccw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd0}, 1'b1, '{11'd3, 16'hF041}},
		'{'{tccw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd1}, 1'b1, '{11'd3, 16'h0F7F}},
		'{'{tccw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd2}, 1'b1, '{11'd3, 16'h5A20}},
		// cursor controls
		'{'{tccw_pkg::MODE_PUT, tccw_pkg::CH_BS, 4'h0, 4'h0, 11'd0}, 1'b1,
			'{11'd2, 16'h0000}},
		'{'{tccw_pkg::MODE_PUT, tccw_pkg::CH_TAB, 4'h0, 4'h0, 11'd0}, 1'b1,
			'{11'd8, 16'h0000}},
		'{'{tccw_pkg::MODE_PUT, tccw_pkg::CH_CR, 4'h0, 4'h0, 11'd0}, 1'b1,
			'{11'd0, 16'h0000}},
		// backspace held at column zero
		'{'{tccw_pkg::MODE_PUT, tccw_pkg::CH_BS, 4'h0, 4'h0, 11'd0}, 1'b1,
			'{11'd0, 16'h0000}},
		'{'{tccw_pkg::MODE_PUT, tccw_pkg::CH_LF, 4'h0, 4'h0, 11'd0}, 1'b1,
			'{11'd80, 16'h0000}},
		// first index past the screen
		'{'{tccw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd2000}, 1'b1, '{11'd80, 16'h0000}},
		'{'{tccw_pkg::MODE_CLEAR, 8'h41, 4'hF, 4'hF, 11'd5}, 1'b1, '{11'd0, 16'h0000}},
		'{'{tccw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd2}, 1'b1,
			'{11'd0, tccw_pkg::BLANK_CELL}},
		'{'{tccw_pkg::MODE_PUT, 8'h7E, 4'h0, 4'h0, 11'd0}, 1'b0, '{11'd0, 16'h0000}},
		'{'{tccw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd0}, 1'b0, '{11'd0, 16'h0000}}
	};

	text_console_cell_writer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus)
	);

	always #4 clk = ~clk;

	// shadow console: applies one item and returns the result it must give
	function automatic tccw_pkg::result_t console_step(input tccw_pkg::item_t it);
		tccw_pkg::result_t r;
		int unsigned       idx;
		int                i;
		r = '0;
		case (it.mode)
			tccw_pkg::MODE_PUT: begin
				if (it.char_code == tccw_pkg::CH_BS) begin
					if (shadow_col != 0)
						shadow_col--;
				end else if (it.char_code == tccw_pkg::CH_TAB) begin
					shadow_col = (shadow_col + TAB_STOP) & ~(TAB_STOP - 1);
				end else if (it.char_code == tccw_pkg::CH_CR) begin
					shadow_col = 0;
				end else if (it.char_code == tccw_pkg::CH_LF) begin
					shadow_col = 0;
					shadow_row++;
				end else if (it.char_code >= tccw_pkg::CH_SPACE &&
						it.char_code <= CH_LAST_PRINT) begin
					idx = shadow_row * COLS + shadow_col;
					if (idx < CELLS)
						shadow_cells[idx] = {it.back_color, it.fore_color, it.char_code};
					shadow_col++;
				end
				// line end wraps to the next row
				if (shadow_col >= COLS) begin
					shadow_col = 0;
					shadow_row++;
					n_wrap++;
				end
				// leaving the last row scrolls everything up one row
				if (shadow_row >= LINES) begin
					for (i = 0; i < CELLS - COLS; i++)
						shadow_cells[i] = shadow_cells[i + COLS];
					for (i = CELLS - COLS; i < CELLS; i++)
						shadow_cells[i] = tccw_pkg::BLANK_CELL;
					shadow_row = LINES - 1;
					n_scroll++;
				end
			end
			tccw_pkg::MODE_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					shadow_cells[i] = tccw_pkg::BLANK_CELL;
				shadow_col = 0;
				shadow_row = 0;
				n_clear++;
			end
			tccw_pkg::MODE_READ: begin
				if (it.read_index < CELLS)
					r.cell_value = shadow_cells[it.read_index];
				n_read++;
			end
			default: ;
		endcase
		r.cursor_pos = tccw_pkg::LOC_W'(shadow_row * COLS + shadow_col);
		return r;
	endfunction

	// random item, weighted so the cursor keeps moving down and scrolling
	function automatic tccw_pkg::item_t random_item();
		tccw_pkg::item_t it;
		int              pick;
		it.back_color = 4'($urandom_range(15));
		it.fore_color = 4'($urandom_range(15));
		pick = $urandom_range(999);
		if (pick < 3)
			it.mode = tccw_pkg::MODE_CLEAR;
		else if (pick < 20)
			it.mode = MODE_UNUSED;
		else if (pick < 200)
			it.mode = tccw_pkg::MODE_READ;
		else
			it.mode = tccw_pkg::MODE_PUT;
		pick = $urandom_range(99);
		if (pick < 60)
			it.char_code = 8'($urandom_range(CH_LAST_PRINT, tccw_pkg::CH_SPACE));
		else if (pick < 72)
			it.char_code = tccw_pkg::CH_LF;
		else if (pick < 76)
			it.char_code = tccw_pkg::CH_CR;
		else if (pick < 81)
			it.char_code = tccw_pkg::CH_BS;
		else if (pick < 86)
			it.char_code = tccw_pkg::CH_TAB;
		else if (pick < 93)
			it.char_code = 8'($urandom_range(tccw_pkg::CH_SPACE - 1, 0));
		else
			it.char_code = 8'($urandom_range(255, 128));
		pick = $urandom_range(99);
		if (pick < 60)
			it.read_index = tccw_pkg::INDEX_W'($urandom_range(CELLS - 1));
		else if (pick < 85)
			// the row the cursor is writing into
			it.read_index = tccw_pkg::INDEX_W'(shadow_row * COLS + $urandom_range(COLS - 1));
		else
			it.read_index = tccw_pkg::INDEX_W'($urandom_range(2047, CELLS));
		return it;
	endfunction

	// one input transfer: optional idle gap, then hold until accepted
	task automatic drive_item(input tccw_pkg::item_t it, input logic known,
			input tccw_pkg::result_t known_res);
		tccw_pkg::result_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item_bus   <= it;
		do
			@(posedge clk);
		while (item_stall);
		pred = console_step(it);
		expected_results.push_back(known ? known_res : pred);
		n_in++;
		@(negedge clk);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// output transfer check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_out++;
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: cursor_pos %0d cell_value %04h",
					result_bus.cursor_pos, result_bus.cell_value);
				errors++;
			end else begin
				exp_res = expected_results.pop_front();
				if (result_bus.cursor_pos !== exp_res.cursor_pos) begin
					$error("cursor_pos: expected %0d, actual %0d",
						exp_res.cursor_pos, result_bus.cursor_pos);
					errors++;
				end
				if (result_bus.cell_value !== exp_res.cell_value) begin
					$error("cell_value: expected %04h, actual %04h",
						exp_res.cell_value, result_bus.cell_value);
					errors++;
				end
			end
		end
	end

	initial begin
		int i;
		int phase;
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item_bus       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		errors = 0;
		n_in = 0; n_out = 0; n_read = 0; n_wrap = 0; n_scroll = 0; n_clear = 0;
		for (i = 0; i < CELLS; i++)
			shadow_cells[i] = tccw_pkg::BLANK_CELL;
		shadow_col = 0;
		shadow_row = 0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, no idling; the block stalls through its clearing pass first
		for (i = 0; i < DIR_N; i++)
			drive_item(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].res);

		// random phases: none, sender idle, receiver stall, both
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			for (i = 0; i < PHASE_ITEMS; i++)
				drive_item(random_item(), 1'b0, '0);
			// hold off until every outstanding transfer has come back
			item_valid <= 1'b0;
			do
				@(negedge clk);
			while (expected_results.size() != 0);
		end

		// catch any stray result
		recv_stall_pct = 0;
		repeat (50) @(posedge clk);

		$display("run covered %0d transfers in, %0d out: %0d reads, %0d line wraps",
			n_in, n_out, n_read, n_wrap);
		$display("  %0d scroll passes, %0d clears, over four idle/stall mixes",
			n_scroll, n_clear);
		if (errors == 0)
			$display("[text_console_cell_writer] OK");
		else
			$display("[text_console_cell_writer] ERROR");
		$finish;
	end

	// hard stop: far beyond every item paying a full-screen pass under heavy stalls
	initial begin
		#80_000_000;
		$display("[text_console_cell_writer] ERROR");
		$finish;
	end

endmodule

[text_console_cell_writer.f]
design/tccw_pkg.sv
design/text_console_cell_writer.sv
tb/tb.sv
